>>> rtl/olc_pkg.sv
package olc_pkg;

  localparam int unsigned RING_DEPTH  = 256;  // power of two: ring index is the low line bits
  localparam int unsigned RING_AW     = $clog2(RING_DEPTH);
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned LINE_W      = 32;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned CHUNK_W     = 9;
  localparam int unsigned OVL_W       = 8;
  localparam int unsigned SIZE_W      = RING_AW + 1;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [7:0]             NEWLINE     = 8'd10;
  localparam logic [CHUNK_W-1:0]     CHUNK_RESET = CHUNK_W'(64);
  localparam logic [OVL_W-1:0]       OVL_RESET   = OVL_W'(8);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX     = '1;
  localparam logic [LINE_W-1:0]      LINE_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_LINES   = 1'b0,
    CFG_OVERLAP_LINES = 1'b1
  } olc_cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_end;
  } olc_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] first_line;
    logic [OUT_W-1:0] last_line;
    logic [OUT_W-1:0] start_byte;
    logic [OUT_W-1:0] end_byte;
  } olc_out_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } olc_buf_status_t;

endpackage

>>> rtl/overlapping_line_chunker_core.sv
// channel | signals                                   | transfer when
// --------+-------------------------------------------+-------------------------
// in      | in_valid_i, in_ready_o, in_data_i         | in_valid_i & in_ready_o
// out     | out_valid_o, out_ready_i, out_data_o      | out_valid_o & out_ready_i
// cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i          | cfg_we_i
//
// One input item per cycle while in_ready_o is high; a chunk is registered in the output buffer before it shows on out.
// The line start ring is a RAM with one write and one read port; its registered read data is
// taken up through a select, and a same-cycle write to the read entry is forwarded.
// A two-entry output buffer keeps in_ready_o high until two results are waiting.
// Reset clears counters and config (chunk 64, overlap 8); no clearing pass, ring left as is.
module overlapping_line_chunker_core import olc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  olc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output olc_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [CHUNK_W-1:0]     chunk_q;
  logic [OVL_W-1:0]       ovl_q;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [LINE_W-1:0]      line_q, line_d;
  logic [LINE_W-1:0]      cf_q, cf_d;
  logic [OFFSET_BITS-1:0] cso_q, cso_d;
  logic                   cso_sel_q, cso_sel_d;  // start offset sits in ram read data

  logic [SIZE_W-1:0]      size;
  logic [SIZE_W-1:0]      ov;
  logic [OFFSET_BITS-1:0] end_off;
  logic [LINE_W-1:0]      line_inc;
  logic [LINE_W-1:0]      diff;
  logic                   emit;
  logic [LINE_W:0]        cf_wide;
  logic [LINE_W-1:0]      cf_new;
  logic [OFFSET_BITS-1:0] cso;
  logic [OFFSET_BITS-1:0] ram_rdata;
  logic [RING_AW-1:0]     waddr, raddr;
  logic                   fwd;
  logic                   in_fire, is_nl;
  logic                   ram_we, ram_re;
  logic                   push;
  olc_out_t               push_data;
  olc_buf_status_t        buf_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RESET;
      ovl_q   <= OVL_RESET;
    end else if (cfg_we_i) begin
      case (olc_cfg_idx_e'(cfg_idx_i))
        CFG_CHUNK_LINES:   chunk_q <= cfg_wdata_i[CHUNK_W-1:0];
        CFG_OVERLAP_LINES: ovl_q   <= cfg_wdata_i[OVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chunk_q == '0) begin
      size = SIZE_W'(1);
    end else if (32'(chunk_q) > RING_DEPTH) begin
      size = SIZE_W'(RING_DEPTH);
    end else begin
      size = SIZE_W'(chunk_q);
    end
    if (32'(ovl_q) > 32'(size) - 32'd1) begin
      ov = size - SIZE_W'(1);
    end else begin
      ov = SIZE_W'(ovl_q);
    end
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign is_nl    = !in_data_i.is_end && (in_data_i.text_byte == NEWLINE);
  assign end_off  = (pos_q == OFF_MAX) ? pos_q : pos_q + OFFSET_BITS'(1);
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_W'(1);
  assign diff     = line_q - cf_q;
  assign emit     = (line_q >= cf_q) && (diff >= LINE_W'(size) - LINE_W'(1));
  assign cf_wide  = {1'b0, line_q} - (LINE_W+1)'(ov) + (LINE_W+1)'(1);
  assign cf_new   = cf_wide[LINE_W] ? LINE_MAX : cf_wide[LINE_W-1:0];
  assign waddr    = line_inc[RING_AW-1:0];
  assign raddr    = cf_new[RING_AW-1:0];
  assign fwd      = (waddr == raddr);
  assign cso      = cso_sel_q ? ram_rdata : cso_q;

  assign ram_we = in_fire && is_nl;
  assign ram_re = ram_we && emit;

  always_comb begin
    pos_d     = pos_q;
    line_d    = line_q;
    cf_d      = cf_q;
    cso_d     = cso_q;
    cso_sel_d = cso_sel_q;
    push      = 1'b0;
    push_data = '{first_line: OUT_W'(cf_q), last_line: OUT_W'(line_q),
                  start_byte: OUT_W'(cso), end_byte: OUT_W'(end_off)};
    if (in_fire) begin
      if (in_data_i.is_end) begin
        push                 = 1'b1;
        push_data.end_byte   = OUT_W'(pos_q);
        pos_d                = '0;
        line_d               = LINE_W'(1);
        cf_d                 = LINE_W'(1);
        cso_d                = '0;
        cso_sel_d            = 1'b0;
      end else if (!is_nl) begin
        pos_d = end_off;
      end else begin
        pos_d  = end_off;
        line_d = line_inc;
        if (emit) begin
          push = 1'b1;
          cf_d = cf_new;
          // ram read misses the write landing this cycle on the same entry
          if (fwd) begin
            cso_d     = end_off;
            cso_sel_d = 1'b0;
          end else begin
            cso_sel_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      line_q    <= LINE_W'(1);
      cf_q      <= LINE_W'(1);
      cso_q     <= '0;
      cso_sel_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      line_q    <= line_d;
      cf_q      <= cf_d;
      cso_q     <= cso_d;
      cso_sel_q <= cso_sel_d;
    end
  end

  olc_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(end_off),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  olc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .status_o   (buf_status)
  );

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_status.skid_valid |-> buf_status.main_valid)
    else $error("skid entry held while output register empty");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.is_end |=> (pos_q == '0) && (line_q == LINE_W'(1)) &&
                                     (cf_q == LINE_W'(1)) && !cso_sel_q)
    else $error("counters not restarted after end of file");

  a_sel_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cso_sel_q) |-> $past(ram_re))
    else $error("start offset select set without a ring read");

  a_first_not_past_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cf_q <= line_q)
    else $error("chunk first line beyond current line");

endmodule

>>> rtl/olc_ram.sv
module olc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/olc_out_buf.sv
module olc_out_buf import olc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  olc_out_t        push_data_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output olc_out_t        out_data_o,
  output olc_buf_status_t status_o
);

  logic     main_valid_q, main_valid_d;
  logic     skid_valid_q, skid_valid_d;
  olc_out_t main_data_q, main_data_d;
  olc_out_t skid_data_q, skid_data_d;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_data_d  = main_data_q;
    skid_data_d  = skid_data_q;
    if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_data_d  = skid_data_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_data_d  = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_data_d  = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;
  assign status_o    = '{main_valid: main_valid_q, skid_valid: skid_valid_q};

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

import olc_pkg::*;

// Predicts line chunks from the accepted byte stream and holds them until they come out.
class chunk_scoreboard;
  logic [CHUNK_W-1:0]     chunk_cfg;
  logic [OVL_W-1:0]       ovl_cfg;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [LINE_W-1:0]      cur_line;
  logic [LINE_W-1:0]      first_line;
  logic [OFFSET_BITS-1:0] first_off;
  logic [OFFSET_BITS-1:0] line_start [RING_DEPTH];
  olc_out_t               chunk_q [$];
  int unsigned            errors;

  function new();
    chunk_cfg = CHUNK_RESET;
    ovl_cfg   = OVL_RESET;
    errors    = 0;
    restart();
  endfunction

  function void restart();
    byte_pos   = '0;
    cur_line   = 1;
    first_line = 1;
    first_off  = '0;
    line_start[1 % RING_DEPTH] = '0;
  endfunction

  function void set_sizes(input int unsigned chunk, input int unsigned ovl);
    chunk_cfg = CHUNK_W'(chunk);
    ovl_cfg   = OVL_W'(ovl);
  endfunction

  function int unsigned pending();
    return chunk_q.size();
  endfunction

  function void note_input(input olc_in_t item);
    longint unsigned        size;
    longint unsigned        ov;
    longint unsigned        first_next;
    logic [OFFSET_BITS-1:0] end_off;
    logic [LINE_W-1:0]      line_next;
    olc_out_t               chunk;
    if (item.is_end) begin
      chunk = '{first_line: first_line, last_line: cur_line,
                start_byte: first_off, end_byte: byte_pos};
      chunk_q.insert(chunk_q.size(), chunk);
      restart();
      return;
    end
    end_off = (byte_pos == OFF_MAX) ? OFF_MAX : byte_pos + 1'b1;
    if (item.text_byte != NEWLINE) begin
      byte_pos = end_off;
      return;
    end
    size = chunk_cfg;
    if (size < 1) size = 1;
    if (size > RING_DEPTH) size = RING_DEPTH;
    ov = ovl_cfg;
    if (ov > size - 1) ov = size - 1;
    line_next = (cur_line == LINE_MAX) ? LINE_MAX : cur_line + 1'b1;
    line_start[line_next[RING_AW-1:0]] = end_off;
    if (cur_line >= first_line &&
        longint'(cur_line) - longint'(first_line) + 1 >= size) begin
      chunk = '{first_line: first_line, last_line: cur_line,
                start_byte: first_off, end_byte: end_off};
      chunk_q.insert(chunk_q.size(), chunk);
      first_next = longint'(cur_line) - ov + 1;
      if (first_next > LINE_MAX) first_next = LINE_MAX;
      first_line = LINE_W'(first_next);
      first_off  = line_start[first_line[RING_AW-1:0]];
    end
    cur_line = line_next;
    byte_pos = end_off;
  endfunction

  function void compare_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(input olc_out_t got);
    olc_out_t want;
    if (chunk_q.size() == 0) begin
      $error("unexpected chunk %0d..%0d", got.first_line, got.last_line);
      errors++;
      return;
    end
    want = chunk_q.pop_front();
    compare_field("first_line", want.first_line, got.first_line);
    compare_field("last_line", want.last_line, got.last_line);
    compare_field("start_byte", want.start_byte, got.start_byte);
    compare_field("end_byte", want.end_byte, got.end_byte);
  endfunction
endclass

module tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1650;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  olc_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  olc_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  chunk_scoreboard board;
  logic            calm = 1'b0;
  int unsigned     sent = 0;
  int unsigned     quiet_cycles = 0;

  overlapping_line_chunker_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random back-pressure unless calm is set, checked on every transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input olc_in_t item);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(item);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    olc_in_t item;
    item.text_byte = b;
    item.is_end    = 1'b0;
    send_item(item);
  endtask

  task automatic send_end();
    olc_in_t item;
    item.text_byte = 8'($urandom_range(255));
    item.is_end    = 1'b1;
    send_item(item);
  endtask

  // Random byte content in which a drawn newline is mostly inverted away; each line ends in a newline.
  task automatic send_line(input int unsigned len);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom_range(255));
      if (b == NEWLINE && $urandom_range(19) != 0) b = ~b;
      send_byte(b);
    end
    send_byte(NEWLINE);
  endtask

  // Stop sending and wait until every chunk has been taken, plus the pipeline tail.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_sizes(input int unsigned chunk, input int unsigned ovl);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CHUNK_LINES;
    cfg_wdata <= CFG_DATA_W'(chunk);
    @(posedge clk);
    cfg_idx   <= CFG_OVERLAP_LINES;
    cfg_wdata <= CFG_DATA_W'(ovl);
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_sizes(chunk, ovl);
  endtask

  initial begin
    int unsigned chunk;
    int unsigned ovl;
    int unsigned files;
    board = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_CHUNK_LINES;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: empty file, then a file of two empty lines
    send_end();
    send_byte(NEWLINE);
    send_end();

    // zero chunk acts as one, oversized overlap gets clamped
    drain();
    load_sizes(0, 255);
    send_byte(8'h00);
    send_byte(NEWLINE);
    send_byte(NEWLINE);
    send_byte(8'hFF);
    send_end();

    // chunk beyond the ring depth, no overlap
    drain();
    load_sizes(511, 0);
    send_byte(8'h7F);
    send_byte(NEWLINE);
    send_byte(NEWLINE);
    send_end();

    drain();
    load_sizes(2, 1);
    send_byte(NEWLINE);
    send_byte(8'h80);
    send_byte(NEWLINE);
    send_byte(NEWLINE);
    send_byte(NEWLINE);
    send_end();

    // long file with full-depth chunks: ring wraps, and after the first chunk every newline closes one
    drain();
    load_sizes(256, 255);
    calm = 1'b1;
    repeat (320) send_line($urandom_range(1));
    send_end();
    drain();
    calm = 1'b0;

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0:       chunk = 0;
        1:       chunk = $urandom_range(511, 257);
        2:       chunk = 256;
        3:       chunk = $urandom_range(40, 7);
        default: chunk = $urandom_range(6, 1);
      endcase
      case ($urandom_range(9))
        0:       ovl = 0;
        1:       ovl = 255;
        2:       ovl = $urandom_range(255);
        default: ovl = $urandom_range((chunk > 255) ? 255 : chunk);
      endcase
      // files may be left open here, so sizes also change in the middle of a file
      drain();
      load_sizes(chunk, ovl);
      files = $urandom_range(3, 1);
      repeat (files) begin
        repeat ($urandom_range(20)) send_line($urandom_range(6));
        if ($urandom_range(3) != 0) send_end();
      end
    end
    send_end();

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
